/* sv/cpu8_pkg.sv */
// cpu8_pkg: operation codes, flag and result types for the cpu8 alu
// no dependencies; imported by cpu8_alu_core and cpu8_alu_with_flags
`default_nettype none

package cpu8_pkg;

  localparam int unsigned DataWidth = 8;
  localparam int unsigned OpWidth   = 4;

  typedef logic [DataWidth-1:0] byte_t;

  typedef enum logic [OpWidth-1:0] {
    OP_LOAD  = 4'd0,
    OP_INC   = 4'd1,
    OP_DEC   = 4'd2,
    OP_ADD   = 4'd3,
    OP_SUB   = 4'd4,
    OP_CMP   = 4'd5,
    OP_AND   = 4'd6,
    OP_OR    = 4'd7,
    OP_XOR   = 4'd8,
    OP_ASL   = 4'd9,
    OP_LSR   = 4'd10,
    OP_ROL   = 4'd11,
    OP_ROR   = 4'd12,
    OP_BIT   = 4'd13,
    OP_STORE = 4'd14
  } alu_op_t;

  typedef struct packed {
    logic negative;
    logic zero;
    logic carry;
  } flags_t;

  typedef struct packed {
    byte_t  data;
    logic   write_enable;
    flags_t flags;
  } alu_res_t;

endpackage

`default_nettype wire

/* sv/cpu8_alu_core.sv */
// cpu8_alu_core: combinational datapath of the alu, one operation per word
// depends on cpu8_pkg for operation codes and the flag/result structs
`default_nettype none

module cpu8_alu_core (
  input  wire logic [cpu8_pkg::OpWidth-1:0] operation,
  input  wire cpu8_pkg::byte_t              operand_a,
  input  wire cpu8_pkg::byte_t              operand_b,
  input  wire logic                         carry_in,
  input  wire cpu8_pkg::flags_t             flags,
  output cpu8_pkg::alu_res_t                res
);
  import cpu8_pkg::*;

  logic [DataWidth:0] add_sum;
  logic [DataWidth:0] sub_diff;
  logic [DataWidth:0] cmp_diff;
  byte_t              and_val;

  // subtract as a + ~b + carry, bit 8 set means no borrow
  assign add_sum  = {1'b0, operand_a} + {1'b0, operand_b} + {{DataWidth{1'b0}}, carry_in};
  assign sub_diff = {1'b0, operand_a} + {1'b0, ~operand_b} + {{DataWidth{1'b0}}, carry_in};
  assign cmp_diff = {1'b0, operand_a} + {1'b0, ~operand_b} + {{DataWidth{1'b0}}, 1'b1};
  assign and_val  = operand_a & operand_b;

  always_comb begin
    res.data         = '0;
    res.write_enable = 1'b1;
    res.flags        = flags;
    unique case (alu_op_t'(operation))
      OP_LOAD: res.data = operand_b;
      OP_INC:  res.data = operand_b + byte_t'(1);
      OP_DEC:  res.data = operand_b - byte_t'(1);
      OP_ADD: begin
        res.data        = add_sum[DataWidth-1:0];
        res.flags.carry = add_sum[DataWidth];
      end
      OP_SUB: begin
        res.data        = sub_diff[DataWidth-1:0];
        res.flags.carry = sub_diff[DataWidth];
      end
      OP_CMP: begin
        res.data         = cmp_diff[DataWidth-1:0];
        res.flags.carry  = cmp_diff[DataWidth];
        res.write_enable = 1'b0;
      end
      OP_AND: res.data = and_val;
      OP_OR:  res.data = operand_a | operand_b;
      OP_XOR: res.data = operand_a ^ operand_b;
      OP_ASL: begin
        res.data        = {operand_b[DataWidth-2:0], 1'b0};
        res.flags.carry = operand_b[DataWidth-1];
      end
      OP_LSR: begin
        res.data        = {1'b0, operand_b[DataWidth-1:1]};
        res.flags.carry = operand_b[0];
      end
      OP_ROL: begin
        res.data        = {operand_b[DataWidth-2:0], flags.carry};
        res.flags.carry = operand_b[DataWidth-1];
      end
      OP_ROR: begin
        res.data        = {flags.carry, operand_b[DataWidth-1:1]};
        res.flags.carry = operand_b[0];
      end
      OP_BIT: begin
        res.data         = and_val;
        res.write_enable = 1'b0;
      end
      OP_STORE: res.data = operand_a;
      default: res.write_enable = 1'b0;
    endcase

    // n and z follow the result byte except for bit test, store and unused codes
    unique case (alu_op_t'(operation))
      OP_LOAD, OP_INC, OP_DEC, OP_ADD, OP_SUB, OP_CMP, OP_AND, OP_OR, OP_XOR,
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        res.flags.negative = res.data[DataWidth-1];
        res.flags.zero     = (res.data == '0);
      end
      OP_BIT: begin
        res.flags.negative = operand_b[DataWidth-1];
        res.flags.zero     = (and_val == '0);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* sv/cpu8_alu_with_flags.sv */
// cpu8_alu_with_flags: 8-bit alu with negative, zero and carry flags
// the input word is registered in the s1 stage, then its result word in the output
// register, and res_stall can hold a word in s1; throughput: one word per cycle
// unless res_stall holds the output; the flag register closes its loop through
// the alu datapath; res_stall reaches item_stall through logic only
// reset: synchronous active-high rst clears both valid bits and all three flags
// depends on cpu8_pkg and cpu8_alu_core
`default_nettype none

module cpu8_alu_with_flags (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire logic [cpu8_pkg::OpWidth-1:0] operation,
  input  wire cpu8_pkg::byte_t              operand_a,
  input  wire cpu8_pkg::byte_t              operand_b,
  input  wire logic                         carry_in,
  output logic                              res_valid,
  input  wire logic                         res_stall,
  output cpu8_pkg::byte_t                   result,
  output logic                              write_enable,
  output logic                              negative_out,
  output logic                              zero_out,
  output logic                              carry_out
);
  import cpu8_pkg::*;

  logic                s1_valid;
  logic [OpWidth-1:0]  s1_op;
  byte_t               s1_a;
  byte_t               s1_b;
  logic                s1_cin;
  flags_t              flags;
  alu_res_t            alu_res;
  alu_res_t            out_res;
  logic                advance;
  logic                accept;

  // the input word moves on when the result register is empty or being taken
  assign advance    = s1_valid && (!res_valid || !res_stall);
  assign item_stall = s1_valid && !advance;
  assign accept     = item_valid && !item_stall;

  cpu8_alu_core u_core (
    .operation (s1_op),
    .operand_a (s1_a),
    .operand_b (s1_b),
    .carry_in  (s1_cin),
    .flags     (flags),
    .res       (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op  <= operation;
      s1_a   <= operand_a;
      s1_b   <= operand_b;
      s1_cin <= carry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      res_valid <= 1'b0;
    end else if (advance) begin
      flags     <= alu_res.flags;
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= alu_res;
    end
  end

  assign result       = out_res.data;
  assign write_enable = out_res.write_enable;
  assign negative_out = out_res.flags.negative;
  assign zero_out     = out_res.flags.zero;
  assign carry_out    = out_res.flags.carry;

endmodule

`default_nettype wire

/* bench/testbench.sv */
// testbench: self-checking bench for the cpu8_alu_with_flags block
// keeps its own copy of the n, z and c flags and predicts every result word
// depends on cpu8_pkg and the cpu8_alu_with_flags rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cpu8_pkg::*;

  localparam logic [OpWidth-1:0] OpUnused   = 4'd15;
  localparam int unsigned        StallLimit = 2000;

  logic                clk;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  logic                item_stall;
  logic [OpWidth-1:0]  operation    = '0;
  byte_t               operand_a    = '0;
  byte_t               operand_b    = '0;
  logic                carry_in     = 1'b0;
  logic                res_valid;
  logic                res_stall    = 1'b0;
  byte_t               result;
  logic                write_enable;
  logic                negative_out;
  logic                zero_out;
  logic                carry_out;

  flags_t      held_flags = '0;
  alu_res_t    expected_words[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned error_count   = 0;
  int unsigned quiet_cycles  = 0;

  cpu8_alu_with_flags dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .carry_in     (carry_in),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .result       (result),
    .write_enable (write_enable),
    .negative_out (negative_out),
    .zero_out     (zero_out),
    .carry_out    (carry_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // expected word for one operation; advances the held flags
  function automatic alu_res_t alu_outcome(logic [OpWidth-1:0] op, byte_t a, byte_t b,
                                           logic cin);
    logic [8:0] wide;
    byte_t      data;
    logic       we;
    logic       sets_nz;
    alu_res_t   word;
    data    = '0;
    we      = 1'b1;
    sets_nz = 1'b1;
    case (op)
      OP_LOAD: data = b;
      OP_INC:  data = b + 8'd1;
      OP_DEC:  data = b - 8'd1;
      OP_ADD: begin
        wide = {1'b0, a} + {1'b0, b} + {8'b0, cin};
        data = wide[7:0];
        held_flags.carry = wide[8];
      end
      OP_SUB, OP_CMP: begin
        // compare is a subtract with no borrow in that leaves the destination alone
        if (op == OP_CMP) begin
          we = 1'b0;
          wide = {1'b0, a} + 9'h100 - {1'b0, b};
        end else begin
          wide = {1'b0, a} + 9'h100 - {1'b0, b} - {8'b0, ~cin};
        end
        data = wide[7:0];
        held_flags.carry = wide[8];
      end
      OP_AND: data = a & b;
      OP_OR:  data = a | b;
      OP_XOR: data = a ^ b;
      OP_ASL: begin
        data = {b[6:0], 1'b0};
        held_flags.carry = b[7];
      end
      OP_LSR: begin
        data = {1'b0, b[7:1]};
        held_flags.carry = b[0];
      end
      OP_ROL: begin
        data = {b[6:0], held_flags.carry};
        held_flags.carry = b[7];
      end
      OP_ROR: begin
        data = {held_flags.carry, b[7:1]};
        held_flags.carry = b[0];
      end
      OP_BIT: begin
        // n comes from the memory byte, z from the masked byte
        data = a & b;
        we = 1'b0;
        sets_nz = 1'b0;
        held_flags.negative = b[7];
        held_flags.zero = (data == '0);
      end
      OP_STORE: begin
        data = a;
        sets_nz = 1'b0;
      end
      default: begin
        we = 1'b0;
        sets_nz = 1'b0;
      end
    endcase
    if (sets_nz) begin
      held_flags.negative = data[7];
      held_flags.zero = (data == '0);
    end
    word.data = data;
    word.write_enable = we;
    word.flags = held_flags;
    return word;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  // edges of extreme values, otherwise uniform
  function automatic byte_t pick_byte();
    case ($urandom_range(15))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h80;
      3: return 8'h7f;
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall)
      expected_words.push_back(alu_outcome(operation, operand_a, operand_b, carry_in));
  end

  always @(posedge clk) begin
    alu_res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: result %0h", result);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        check_field("result", want.data, result);
        check_field("write_enable", want.write_enable, write_enable);
        check_field("negative_out", want.flags.negative, negative_out);
        check_field("zero_out", want.flags.zero, zero_out);
        check_field("carry_out", want.flags.carry, carry_out);
        words_checked++;
      end
    end
  end

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("cpu8_alu_with_flags regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // valid stays high from one word to the next unless a gap is inserted
  task automatic send_word(logic [OpWidth-1:0] op, byte_t a, byte_t b, logic cin);
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    item_valid <= 1'b1;
    operation  <= op;
    operand_a  <= a;
    operand_b  <= b;
    carry_in   <= cin;
    do @(posedge clk); while (item_stall);
    words_sent++;
  endtask

  task automatic test_load_inc_dec();
    send_word(OP_LOAD, 8'h00, 8'h00, 1'b0);
    send_word(OP_LOAD, 8'hff, 8'h80, 1'b1);
    send_word(OP_INC, 8'h00, 8'hff, 1'b0);
    send_word(OP_INC, 8'hff, 8'h7f, 1'b1);
    send_word(OP_DEC, 8'h00, 8'h00, 1'b0);
    send_word(OP_DEC, 8'h55, 8'h01, 1'b1);
  endtask

  task automatic test_add_sub();
    send_word(OP_ADD, 8'hff, 8'h01, 1'b0);
    send_word(OP_ADD, 8'hff, 8'hff, 1'b1);
    send_word(OP_ADD, 8'h00, 8'h00, 1'b0);
    send_word(OP_SUB, 8'h00, 8'h00, 1'b1);
    send_word(OP_SUB, 8'h00, 8'h01, 1'b1);
    send_word(OP_SUB, 8'h80, 8'h7f, 1'b0);
  endtask

  task automatic test_compare_and_bit();
    send_word(OP_CMP, 8'h42, 8'h42, 1'b0);
    send_word(OP_CMP, 8'h00, 8'hff, 1'b1);
    send_word(OP_BIT, 8'h3f, 8'hc0, 1'b0);
    send_word(OP_BIT, 8'hff, 8'h7f, 1'b1);
  endtask

  task automatic test_logic_ops();
    send_word(OP_AND, 8'hf0, 8'h0f, 1'b0);
    send_word(OP_OR, 8'h80, 8'h01, 1'b0);
    send_word(OP_XOR, 8'hff, 8'hff, 1'b1);
  endtask

  task automatic test_shifts_rotates();
    send_word(OP_ASL, 8'h00, 8'h80, 1'b0);
    send_word(OP_ROL, 8'h00, 8'h40, 1'b0);
    send_word(OP_LSR, 8'h00, 8'h01, 1'b0);
    send_word(OP_ROR, 8'h00, 8'hfe, 1'b0);
    send_word(OP_ROR, 8'h00, 8'h01, 1'b0);
  endtask

  task automatic test_store_and_unused();
    send_word(OP_STORE, 8'ha5, 8'h00, 1'b0);
    send_word(OpUnused, 8'hff, 8'hff, 1'b1);
  endtask

  task automatic test_random_stream(int unsigned count, int unsigned tx_pct,
                                    int unsigned rx_pct);
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    repeat (count)
      send_word(OpWidth'($urandom_range(15)), pick_byte(), pick_byte(),
                1'($urandom_range(1)));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_load_inc_dec();
    test_add_sub();
    test_compare_and_bit();
    test_logic_ops();
    test_shifts_rotates();
    test_store_and_unused();
    test_random_stream(342, 11, 85);
    test_random_stream(342, 85, 11);
    test_random_stream(342, 0, 0);
    item_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("sent %0d words over all fifteen operations and the unused code", words_sent);
    $display("checked %0d result words under three sender/receiver idling mixes",
             words_checked);
    if (error_count == 0) begin
      $display("cpu8_alu_with_flags regression: pass");
    end else begin
      $display("cpu8_alu_with_flags regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/cpu8_pkg.sv
sv/cpu8_alu_core.sv
sv/cpu8_alu_with_flags.sv
bench/testbench.sv
